>>> sv/ibfp_pkg.sv
package ibfp_pkg;

  localparam int unsigned FRAME_BYTES = 30;

  localparam logic [7:0] HDR0 = 8'h20;
  localparam logic [7:0] HDR1 = 8'h40;

  // byte positions counted after the two header bytes
  localparam logic [4:0] PAYLOAD_BYTES = 5'(FRAME_BYTES - 2);
  localparam logic [4:0] CKS_HI_POS    = 5'(FRAME_BYTES - 1);

  localparam logic [15:0] SUM_START = 16'hFFFF - {8'h00, HDR0} - {8'h00, HDR1};

  localparam logic [3:0] ACT_CH_RESET = 4'd14;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_HDR1,
    PH_DATA
  } parse_phase_e;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

>>> sv/ibfp_if.sv
interface ibfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface ibfp_out_if;
  logic        valid;
  logic        ready;
  logic        frame_ok;
  logic [3:0]  channel_index;
  logic [15:0] channel_value;
  logic        last;

  modport source (output valid, output frame_ok, output channel_index,
                  output channel_value, output last, input ready);
  modport sink (input valid, input frame_ok, input channel_index,
                input channel_value, input last, output ready);
endinterface

interface ibfp_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] active_channels;

  modport source (output valid, output active_channels, input ready);
  modport sink (input valid, input active_channels, output ready);
endinterface

>>> sv/ibus_frame_parser_top.sv
// iBUS frame decoder. Serial bytes enter on rx_if, one request per cycle;
// the parser hunts for the 0x20 0x40 header, gathers 28 payload bytes and
// the little-endian checksum, and hands each finished frame to a two-entry
// frame queue. The emitter drains the queue and sends one result per cycle
// while res_if is ready: for a good frame the first active_channels words
// (clamped to 1..MAX_CHANNELS) with last on the final one, for a bad
// checksum a single error result with frame_ok low. Input bytes are taken
// every cycle except the checksum high byte, which waits only while both
// queue entries hold frames not yet sent; a frame has more input bytes than
// results, so with a ready sink the parser never stalls. The user writes
// active_channels through cfg_if while the block is idle; the block does not enforce it.
module ibus_frame_parser_top #(
  parameter int unsigned MAX_CHANNELS = 14
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ibfp_in_if.sink     rx_if,
  ibfp_out_if.source  res_if,
  ibfp_cfg_if.sink    cfg_if
);
  import ibfp_pkg::*;

  localparam int unsigned QDW = 1 + MAX_CHANNELS * 16;

  logic [3:0]                    act_ch_q;
  logic                          push;
  logic                          push_ok;
  logic [MAX_CHANNELS-1:0][15:0] push_words;
  logic                          pop;
  q_stat_t                       q_stat;
  logic [QDW-1:0]                q_head;
  logic [MAX_CHANNELS-1:0][15:0] head_words;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_ch_q <= ACT_CH_RESET;
    end else if (cfg_if.valid) begin
      act_ch_q <= cfg_if.active_channels;
    end
  end

  ibfp_front #(
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_if       (rx_if),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .push_ok_o   (push_ok),
    .push_words_o(push_words)
  );

  ibfp_queue #(
    .DW(QDW)
  ) u_queue (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(push),
    .data_i({push_ok, push_words}),
    .pop_i (pop),
    .stat_o(q_stat),
    .data_o(q_head)
  );

  assign head_words = q_head[QDW-2:0];

  ibfp_back #(
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_stat_i   (q_stat),
    .job_ok_i   (q_head[QDW-1]),
    .job_words_i(head_words),
    .act_ch_i   (act_ch_q),
    .pop_o      (pop),
    .res_if     (res_if)
  );

  // a finished frame is never pushed into a full queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_stat.full)
    else $error("frame pushed into full queue");

  // the emitter only retires a frame that is there
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_stat.empty)
    else $error("frame popped from empty queue");

  // an error result is a lone, empty result
  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_if.valid && !res_if.frame_ok) |->
      (res_if.last && res_if.channel_index == 4'd0 && res_if.channel_value == 16'd0))
    else $error("malformed error result");

  // channel indexes stay inside the kept channels
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_if.valid && res_if.frame_ok) |-> (res_if.channel_index < 4'(MAX_CHANNELS)))
    else $error("channel index out of range");

endmodule

>>> sv/ibfp_front.sv
module ibfp_front #(
  parameter int unsigned MAX_CHANNELS = 14
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  ibfp_in_if.sink                        rx_if,
  input  ibfp_pkg::q_stat_t              q_stat_i,
  output logic                           push_o,
  output logic                           push_ok_o,
  output logic [MAX_CHANNELS-1:0][15:0]  push_words_o
);
  import ibfp_pkg::*;

  localparam int unsigned IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  parse_phase_e phase_q, phase_d;
  logic [4:0]   cnt_q, cnt_d;
  logic [15:0]  sum_q, sum_d;
  logic [7:0]   cks_lo_q, cks_lo_d;
  logic [MAX_CHANNELS-1:0][15:0] store_q;

  logic             acc;
  logic             at_last;
  logic             store_we;
  logic [3:0]       word_sel;
  logic [IDX_W-1:0] widx;

  // the checksum high byte is held off only while both queue slots are taken
  assign at_last     = (phase_q == PH_DATA) && (cnt_q == CKS_HI_POS);
  assign rx_if.ready = !(at_last && q_stat_i.full);
  assign acc         = rx_if.valid && rx_if.ready;

  assign word_sel = cnt_q[4:1];
  assign widx     = word_sel[IDX_W-1:0];

  always_comb begin
    phase_d = phase_q;
    if (acc) begin
      case (phase_q)
        PH_HUNT: begin
          if (rx_if.rx_byte == HDR0) phase_d = PH_HDR1;
        end
        PH_HDR1: begin
          if (rx_if.rx_byte == HDR1) begin
            phase_d = PH_DATA;
          end else if (rx_if.rx_byte != HDR0) begin
            phase_d = PH_HUNT;
          end
        end
        PH_DATA: begin
          if (at_last) phase_d = PH_HUNT;
        end
        default: phase_d = PH_HUNT;
      endcase
    end
  end

  always_comb begin
    cnt_d    = cnt_q;
    sum_d    = sum_q;
    cks_lo_d = cks_lo_q;
    store_we = 1'b0;
    push_o   = 1'b0;
    if (acc) begin
      case (phase_q)
        PH_HDR1: begin
          if (rx_if.rx_byte == HDR1) begin
            cnt_d = '0;
            sum_d = SUM_START;
          end
        end
        PH_DATA: begin
          if (cnt_q < PAYLOAD_BYTES) begin
            // words past the kept channels only feed the checksum
            store_we = (word_sel < 4'(MAX_CHANNELS));
            sum_d    = sum_q - {8'h00, rx_if.rx_byte};
            cnt_d    = cnt_q + 5'd1;
          end else if (cnt_q == PAYLOAD_BYTES) begin
            cks_lo_d = rx_if.rx_byte;
            cnt_d    = cnt_q + 5'd1;
          end else begin
            push_o = 1'b1;
            cnt_d  = '0;
          end
        end
        default: ;
      endcase
    end
  end

  assign push_ok_o    = ({rx_if.rx_byte, cks_lo_q} == sum_q);
  assign push_words_o = store_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HUNT;
      cnt_q    <= '0;
      sum_q    <= SUM_START;
      cks_lo_q <= '0;
    end else begin
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
      sum_q    <= sum_d;
      cks_lo_q <= cks_lo_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_we) begin
      if (cnt_q[0]) begin
        store_q[widx][15:8] <= rx_if.rx_byte;
      end else begin
        store_q[widx][7:0] <= rx_if.rx_byte;
      end
    end
  end

endmodule

>>> sv/ibfp_queue.sv
module ibfp_queue #(
  parameter int unsigned DW = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DW-1:0]     data_i,
  input  logic              pop_i,
  output ibfp_pkg::q_stat_t stat_o,
  output logic [DW-1:0]     data_o
);
  import ibfp_pkg::*;

  localparam int unsigned DEPTH = 2;
  localparam int unsigned PW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(DEPTH + 1);

  logic [DW-1:0] mem_q [DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign stat_o.full  = (cnt_q == CW'(DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign data_o       = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + PW'(1);
      if (do_pop) rd_q <= rd_q + PW'(1);
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

endmodule

>>> sv/ibfp_back.sv
module ibfp_back #(
  parameter int unsigned MAX_CHANNELS = 14
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ibfp_pkg::q_stat_t             q_stat_i,
  input  logic                          job_ok_i,
  input  logic [MAX_CHANNELS-1:0][15:0] job_words_i,
  input  logic [3:0]                    act_ch_i,
  output logic                          pop_o,
  ibfp_out_if.source                    res_if
);
  import ibfp_pkg::*;

  localparam int unsigned IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  logic [3:0]       cnt_q;
  logic [3:0]       n_eff;
  logic [IDX_W-1:0] cidx;
  logic             vld_q;
  logic             ok_q;
  logic [3:0]       idx_q;
  logic [15:0]      val_q;
  logic             last_q;
  logic             load;
  logic             last_ch;

  // clamp the channel count into 1..MAX_CHANNELS
  always_comb begin
    if (act_ch_i == 4'd0) begin
      n_eff = 4'd1;
    end else if (act_ch_i > 4'(MAX_CHANNELS)) begin
      n_eff = 4'(MAX_CHANNELS);
    end else begin
      n_eff = act_ch_i;
    end
  end

  assign cidx    = cnt_q[IDX_W-1:0];
  assign load    = !q_stat_i.empty && (!vld_q || res_if.ready);
  assign last_ch = !job_ok_i || (cnt_q == n_eff - 4'd1);
  assign pop_o   = load && last_ch;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (load) begin
        vld_q <= 1'b1;
        cnt_q <= last_ch ? 4'd0 : cnt_q + 4'd1;
      end else if (res_if.ready) begin
        vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      ok_q   <= job_ok_i;
      idx_q  <= job_ok_i ? cnt_q : 4'd0;
      val_q  <= job_ok_i ? job_words_i[cidx] : 16'd0;
      last_q <= last_ch;
    end
  end

  assign res_if.valid         = vld_q;
  assign res_if.frame_ok      = ok_q;
  assign res_if.channel_index = idx_q;
  assign res_if.channel_value = val_q;
  assign res_if.last          = last_q;

endmodule
